// File: rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int N_CELLS  = 16;
	localparam int N_DIGEST = 5;
	localparam int COUNT_W  = 61;
	localparam int ROUNDS   = 80;
	localparam int ROUND_W  = $clog2(ROUNDS);
	localparam int IDX_W    = $clog2(N_DIGEST);
	localparam int POS_W    = 6;
	localparam int LEN_W    = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t chain_t [N_DIGEST];

	// initial chaining values
	localparam word_t H_INIT [N_DIGEST] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	// round constants, one per group of twenty rounds
	localparam word_t K_ROUND [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
	localparam logic [POS_W-1:0]  POS_LAST = 6'd63;
	localparam logic [POS_W-1:0]  POS_LEN  = 6'd56;
	localparam logic [IDX_W-1:0]  IDX_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADDH,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} pad_phase_t;

	// control from the sequencer to the round unit
	typedef struct packed {
		logic load;
		logic step;
	} round_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sha1sh_if.sv
// ----------------------------------------------------------------------------
// sha1sh_in_if / sha1sh_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1sh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1sh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Byte-serial SHA-1: packs bytes into a 16-cell word chain that doubles as
// the message schedule, compresses each block one round per cycle, pads the
// message and returns the digest as five words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while idle; after the 64th byte of a block
//   the input stalls for the 80 rounds in the single round unit and the
//   chaining add (the load shares the byte's cycle).
// After a last word: padding bytes plus one or two compressions,
//   then five digest words, one per cycle while the sink is ready.
// Reset: chaining values to the SHA-1 initial values, counters cleared, idle.
`default_nettype none

module sha1_stream_hasher (
	input  wire          clk,
	input  wire          arst_n,
	sha1sh_in_if.sink    msg,
	sha1sh_out_if.source digest
);

	sha1sh_pkg::state_t                  state_q, state_d;
	sha1sh_pkg::pad_phase_t              ph_q;
	logic [sha1sh_pkg::POS_W-1:0]        pos_q;
	logic [sha1sh_pkg::COUNT_W-1:0]      count_q;
	logic [23:0]                         acc_q;
	logic [2:0]                          len_idx_q;
	logic                                pad_q, done_q;
	logic [sha1sh_pkg::IDX_W-1:0]        out_idx_q;
	sha1sh_pkg::chain_t                  h_q;

	logic                                accept, out_take, out_end;
	logic                                byte_en, word_push, len_byte;
	logic [sha1sh_pkg::BYTE_W-1:0]       byte_val, len_sel;
	logic [sha1sh_pkg::LEN_W-1:0]        len64;
	sha1sh_pkg::round_ctrl_t             rctl;
	sha1sh_pkg::chain_t                  vars;
	logic                                last_round;
	sha1sh_pkg::word_t                   cell_q [sha1sh_pkg::N_CELLS];
	sha1sh_pkg::word_t                   cell_d [sha1sh_pkg::N_CELLS];
	sha1sh_pkg::word_t                   sched_w;
	logic                                chain_shift;

	assign accept   = msg.valid && msg.ready;
	assign out_take = digest.valid && digest.ready;
	assign out_end  = out_take && (out_idx_q == sha1sh_pkg::IDX_LAST);

	// message bit length, most significant byte first
	assign len64   = {count_q, 3'b000};
	assign len_sel = len64[(3'd7 - len_idx_q) * 8 +: 8];

	// byte source: input word or padding generator
	always_comb begin
		byte_en  = 1'b0;
		byte_val = '0;
		len_byte = 1'b0;
		if (state_q == sha1sh_pkg::ST_IDLE) begin
			byte_en  = accept && msg.has_byte;
			byte_val = msg.data_byte;
		end else if (state_q == sha1sh_pkg::ST_PAD) begin
			byte_en = 1'b1;
			unique case (ph_q)
				sha1sh_pkg::PH_MARK: byte_val = sha1sh_pkg::PAD_MARK;
				sha1sh_pkg::PH_ZERO: begin
					len_byte = (pos_q == sha1sh_pkg::POS_LEN);
					byte_val = len_byte ? len_sel : '0;
				end
				default: begin
					len_byte = 1'b1;
					byte_val = len_sel;
				end
			endcase
		end
	end

	assign word_push = byte_en && (pos_q[1:0] == 2'b11);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1sh_pkg::ST_IDLE: begin
				if (accept) begin
					if (msg.has_byte && pos_q == sha1sh_pkg::POS_LAST) begin
						state_d = sha1sh_pkg::ST_ROUND;
					end else if (msg.last) begin
						state_d = sha1sh_pkg::ST_PAD;
					end
				end
			end
			sha1sh_pkg::ST_PAD: begin
				if (pos_q == sha1sh_pkg::POS_LAST) begin
					state_d = sha1sh_pkg::ST_ROUND;
				end
			end
			sha1sh_pkg::ST_ROUND: begin
				if (last_round) begin
					state_d = sha1sh_pkg::ST_ADDH;
				end
			end
			sha1sh_pkg::ST_ADDH: begin
				priority if (!pad_q) begin
					state_d = sha1sh_pkg::ST_IDLE;
				end else if (done_q) begin
					state_d = sha1sh_pkg::ST_OUT;
				end else begin
					state_d = sha1sh_pkg::ST_PAD;
				end
			end
			sha1sh_pkg::ST_OUT: begin
				if (out_end) begin
					state_d = sha1sh_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1sh_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		msg.ready    = (state_q == sha1sh_pkg::ST_IDLE);
		digest.valid = (state_q == sha1sh_pkg::ST_OUT);
		rctl.load    = byte_en && (pos_q == sha1sh_pkg::POS_LAST);
		rctl.step    = (state_q == sha1sh_pkg::ST_ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1sh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// byte position, message length and padding control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			count_q   <= '0;
			pad_q     <= 1'b0;
			done_q    <= 1'b0;
			ph_q      <= sha1sh_pkg::PH_MARK;
			len_idx_q <= '0;
			out_idx_q <= '0;
		end else begin
			if (byte_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (accept && msg.has_byte) begin
				count_q <= count_q + 61'd1;
			end
			if (accept && msg.last) begin
				pad_q     <= 1'b1;
				ph_q      <= sha1sh_pkg::PH_MARK;
				len_idx_q <= '0;
			end
			if (state_q == sha1sh_pkg::ST_PAD) begin
				if (ph_q == sha1sh_pkg::PH_MARK) begin
					ph_q <= sha1sh_pkg::PH_ZERO;
				end else if (len_byte) begin
					ph_q      <= sha1sh_pkg::PH_LEN;
					len_idx_q <= len_idx_q + 3'd1;
					if (len_idx_q == 3'd7) begin
						done_q <= 1'b1;
					end
				end
			end
			if (out_take) begin
				out_idx_q <= out_end ? '0 : out_idx_q + 3'd1;
			end
			if (out_end) begin
				count_q <= '0;
				pad_q   <= 1'b0;
				done_q  <= 1'b0;
			end
		end
	end

	// partial word accumulator
	always_ff @(posedge clk) begin
		if (byte_en) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
	end

	// chaining values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= sha1sh_pkg::H_INIT;
		end else if (state_q == sha1sh_pkg::ST_ADDH) begin
			for (int i = 0; i < sha1sh_pkg::N_DIGEST; i++) begin
				h_q[i] <= h_q[i] + vars[i];
			end
		end else if (out_end) begin
			h_q <= sha1sh_pkg::H_INIT;
		end
	end

	// schedule expansion feeds the tail cell during rounds
	assign sched_w = cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0];
	assign chain_shift = word_push || rctl.step;

	always_comb begin
		for (int i = 0; i < sha1sh_pkg::N_CELLS - 1; i++) begin
			cell_d[i] = cell_q[i+1];
		end
		cell_d[sha1sh_pkg::N_CELLS-1] = rctl.step ? {sched_w[30:0], sched_w[31]}
		                                          : {acc_q, byte_val};
	end

	// word chain: cell 0 holds the current schedule word
	for (genvar g = 0; g < sha1sh_pkg::N_CELLS; g++) begin : g_cell
		sha1sh_cell u_cell (
			.clk   (clk),
			.shift (chain_shift),
			.d     (cell_d[g]),
			.q     (cell_q[g])
		);
	end

	sha1sh_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (rctl),
		.h          (h_q),
		.w          (cell_q[0]),
		.vars       (vars),
		.last_round (last_round)
	);

	// digest words
	assign digest.digest_word = h_q[out_idx_q];
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = (out_idx_q == sha1sh_pkg::IDX_LAST);

endmodule

`default_nettype wire

// File: rtl/sha1sh_cell.sv
// ----------------------------------------------------------------------------
// sha1sh_cell
// One word of the block / message schedule shift chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_cell (
	input  wire                 clk,
	input  wire                 shift,
	input  sha1sh_pkg::word_t   d,
	output sha1sh_pkg::word_t   q
);

	sha1sh_pkg::word_t word_q;

	// take the neighbor's word whenever the chain moves
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

// File: rtl/sha1sh_round.sv
// ----------------------------------------------------------------------------
// sha1sh_round
// Working variables a..e and one SHA-1 round per cycle while step is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_round (
	input  wire                       clk,
	input  wire                       arst_n,
	input  sha1sh_pkg::round_ctrl_t   ctrl,
	input  sha1sh_pkg::chain_t        h,
	input  sha1sh_pkg::word_t         w,
	output sha1sh_pkg::chain_t        vars,
	output logic                      last_round
);

	sha1sh_pkg::word_t                  a_q, b_q, c_q, d_q, e_q;
	logic [sha1sh_pkg::ROUND_W-1:0]     t_q;
	sha1sh_pkg::word_t                  f, k, tmp;

	// round function and constant by round group
	always_comb begin
		if (t_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1sh_pkg::K_ROUND[0];
		end else if (t_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K_ROUND[1];
		end else if (t_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1sh_pkg::K_ROUND[2];
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1sh_pkg::K_ROUND[3];
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (ctrl.load) begin
			t_q <= '0;
		end else if (ctrl.step) begin
			t_q <= t_q + 7'd1;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= h[0];
			b_q <= h[1];
			c_q <= h[2];
			d_q <= h[3];
			e_q <= h[4];
		end else if (ctrl.step) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign vars[0]    = a_q;
	assign vars[1]    = b_q;
	assign vars[2]    = c_q;
	assign vars[3]    = d_q;
	assign vars[4]    = e_q;
	assign last_round = (t_q == 7'(sha1sh_pkg::ROUNDS - 1));

endmodule

`default_nettype wire

// File: bench/sha1_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Feeds message bytes to the SHA-1 hasher with bursty valid and a stalling
// sink. Each accepted input word goes through a local SHA-1 model whose digest
// words queue up and are matched field by field against the output channel.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// sha-1 initial chaining values and round constants
	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam logic [31:0] SHA1_K [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} msg_word_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_exp_t;

	logic clk;
	logic arst_n;

	sha1sh_in_if  msg_ch ();
	sha1sh_out_if dig_ch ();

	sha1_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch.sink),
		.digest (dig_ch.source)
	);

	// message words waiting to be sent, digest words waiting to be seen
	msg_word_t   pending_words [$];
	digest_exp_t digest_due [$];
	int          fail_count = 0;

	// local hash state
	logic [31:0] chain_q [5];
	logic [31:0] block_q [16];
	logic [60:0] byte_cnt;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic clear_hash();
		for (int i = 0; i < 5; i++)
			chain_q[i] = SHA1_IV[i];
		for (int i = 0; i < 16; i++)
			block_q[i] = '0;
		byte_cnt = '0;
	endtask

	// 80-round compression of the block buffer into the chain, then clear the block
	task automatic compress_block();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, k, tmp;
		for (int t = 0; t < 16; t++)
			sched[t] = block_q[t];
		for (int t = 16; t < 80; t++)
			sched[t] = rotl(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		e = chain_q[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = SHA1_K[0];
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = SHA1_K[1];
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = SHA1_K[2];
			end else begin
				f = b ^ c ^ d;
				k = SHA1_K[3];
			end
			tmp = rotl(a, 5) + f + e + k + sched[t];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = tmp;
		end
		chain_q[0] += a;
		chain_q[1] += b;
		chain_q[2] += c;
		chain_q[3] += d;
		chain_q[4] += e;
		for (int i = 0; i < 16; i++)
			block_q[i] = '0;
	endtask

	// big-endian byte lane within the 16-word block
	task automatic put_byte(input logic [5:0] pos, input logic [7:0] b);
		block_q[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
	endtask

	// absorb one accepted message word, queue the digest on the last one
	task automatic absorb_word(input msg_word_t w);
		logic [5:0]  pos;
		logic [63:0] bit_len;
		digest_exp_t de;
		if (w.has_byte) begin
			pos = byte_cnt[5:0];
			put_byte(pos, w.data_byte);
			byte_cnt = byte_cnt + 1'b1;
			if (pos == 6'd63)
				compress_block();
		end
		if (w.last) begin
			pos = byte_cnt[5:0];
			put_byte(pos, PAD_BYTE);
			if (pos >= 6'd56)
				compress_block();
			bit_len = {byte_cnt, 3'b000};
			block_q[14] = bit_len[63:32];
			block_q[15] = bit_len[31:0];
			compress_block();
			for (int i = 0; i < 5; i++) begin
				de.digest_word = chain_q[i];
				de.word_index  = 3'(i);
				de.last_word   = (i == 4);
				digest_due.push_back(de);
			end
			clear_hash();
		end
	endtask

	// stimulus helpers
	task automatic queue_word(input logic [7:0] d, input logic h, input logic l);
		msg_word_t w;
		w.data_byte = d;
		w.has_byte  = h;
		w.last      = l;
		pending_words.push_back(w);
	endtask

	// random-content message with stray byte-less words, ended on its last byte or by a byte-less last word
	task automatic queue_message(input int len, ref int n_words);
		logic end_on_byte;
		end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_word(8'($urandom), 1'b0, 1'b0);
			queue_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
			n_words++;
		end
		if (!end_on_byte) begin
			queue_word(8'($urandom), 1'b0, 1'b1);
			n_words++;
		end
	endtask

	// driver: bursts of words with random gaps between them
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : drive
		msg_word_t nxt;
		msg_word_t cur;
		if (!arst_n) begin
			msg_ch.valid     <= 1'b0;
			msg_ch.data_byte <= '0;
			msg_ch.has_byte  <= 1'b0;
			msg_ch.last      <= 1'b0;
			burst_left       <= 0;
			gap_left         <= 0;
			clear_hash();
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				cur.data_byte = msg_ch.data_byte;
				cur.has_byte  = msg_ch.has_byte;
				cur.last      = msg_ch.last;
				absorb_word(cur);
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				if (gap_left > 0) begin
					gap_left     <= gap_left - 1;
					msg_ch.valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					nxt = pending_words.pop_front();
					msg_ch.valid     <= 1'b1;
					msg_ch.data_byte <= nxt.data_byte;
					msg_ch.has_byte  <= nxt.has_byte;
					msg_ch.last      <= nxt.last;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: rotating stall pattern, reloaded when its age counter runs out; some stretches never stall
	logic [31:0] stall_pat;
	int          pat_age;

	always @(posedge clk or negedge arst_n) begin : watch
		digest_exp_t de;
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			stall_pat    <= '1;
			pat_age      <= 0;
		end else begin
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_due.size() == 0) begin
					$display("%0t: unexpected digest word %h index %0d last %0b", $time,
						dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
					fail_count++;
				end else begin
					de = digest_due.pop_front();
					if (dig_ch.digest_word !== de.digest_word) begin
						$display("%0t: digest_word expected %h actual %h", $time,
							de.digest_word, dig_ch.digest_word);
						fail_count++;
					end
					if (dig_ch.word_index !== de.word_index) begin
						$display("%0t: word_index expected %0d actual %0d", $time,
							de.word_index, dig_ch.word_index);
						fail_count++;
					end
					if (dig_ch.last_word !== de.last_word) begin
						$display("%0t: last_word expected %0b actual %0b", $time,
							de.last_word, dig_ch.last_word);
						fail_count++;
					end
				end
			end
			dig_ch.ready <= stall_pat[0];
			if (pat_age == 0) begin
				stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
				pat_age   <= 31;
			end else begin
				stall_pat <= {stall_pat[0], stall_pat[31:1]};
				pat_age   <= pat_age - 1;
			end
		end
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// reset, stimulus and end of run
	initial begin
		int n_words;
		arst_n = 1'b0;

		// directed: ignored word, empty messages, extremes of the byte, "abc"
		queue_word(8'hff, 1'b0, 1'b0);
		queue_word(8'h5a, 1'b0, 1'b1);
		queue_word(8'h00, 1'b0, 1'b1);
		queue_word(8'hff, 1'b1, 1'b1);
		queue_word(8'h00, 1'b1, 1'b1);
		queue_word(8'h61, 1'b1, 1'b0);
		queue_word(8'h62, 1'b1, 1'b0);
		queue_word(8'h63, 1'b1, 1'b1);
		queue_word(8'h00, 1'b1, 1'b0);
		queue_word(8'hff, 1'b1, 1'b0);
		queue_word(8'ha5, 1'b0, 1'b0);
		queue_word(8'hff, 1'b0, 1'b1);
		queue_word(8'h00, 1'b0, 1'b1);

		// random: padding spills into a second block, then a full block mid-message, then short messages
		n_words = 0;
		queue_message($urandom_range(56, 63), n_words);
		queue_message($urandom_range(64, 71), n_words);
		while (n_words < 110) begin
			queue_message($urandom_range(0, 9), n_words);
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_words.size() == 0 && !msg_ch.valid);
		wait (digest_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
